[hdl/ssil_pkg.sv]
package ssil_pkg;

  // Set capacity and derived widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 31;
  localparam int unsigned GRP_W    = 8;
  localparam int unsigned NUM_GRP  = (CAPACITY + GRP_W - 1) / GRP_W;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_NEGATIVE  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_FOUND     = 3'd4,
    STAT_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_RED,
    FSM_DEC
  } fsm_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] element_count;
  } out_word_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             ins_en;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

[hdl/ssil_cell.sv]
module ssil_cell
  import ssil_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             valid_i,
  input  logic [VAL_W-1:0] prev_entry_i,
  input  logic             prev_lt_i,
  output logic [VAL_W-1:0] entry_o,
  output logic             lt_o,
  output logic             eq_o
);

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             lt_q, eq_q;

  // Compare flags, captured once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      lt_q <= valid_i && (entry_q < ctl_i.value);
      eq_q <= valid_i && (entry_q == ctl_i.value);
    end
  end

  // Insert: keep if smaller, take the new value at the boundary, else shift up
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en && !lt_q) begin
      if (prev_lt_i) begin
        entry_d = ctl_i.value;
      end else begin
        entry_d = prev_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

[hdl/ssil_chain.sv]
module ssil_chain
  import ssil_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             red_en_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             present_o
);

  logic [CAPACITY-1:0][VAL_W-1:0] entry;
  logic [CAPACITY-1:0]            lt;
  logic [CAPACITY-1:0]            eq;
  logic [NUM_GRP*GRP_W-1:0]       eq_pad;
  logic [NUM_GRP-1:0]             grp_d, grp_q;

  // Row of cells; cell 0 sees an always-smaller neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] prev_entry;
    logic             prev_lt;
    if (g == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_entry = entry[g-1];
      assign prev_lt    = lt[g-1];
    end
    ssil_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .valid_i      (count_i > CNT_W'(g)),
      .prev_entry_i (prev_entry),
      .prev_lt_i    (prev_lt),
      .entry_o      (entry[g]),
      .lt_o         (lt[g]),
      .eq_o         (eq[g])
    );
  end

  // Match reduction: registered group ORs, then a short final OR
  always_comb begin
    eq_pad                = '0;
    eq_pad[CAPACITY-1:0]  = eq;
    for (int k = 0; k < NUM_GRP; k++) begin
      grp_d[k] = |eq_pad[k*GRP_W +: GRP_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else if (red_en_i) begin
      grp_q <= grp_d;
    end
  end

  assign present_o = |grp_q;

endmodule

[hdl/sorted_set_insert_lookup_unit.sv]
// The sequence is accept, cell compare, match reduction, decide/shift, all
// through one shared row of cells. Decide waits for a free result register,
// and a new word is accepted only after decide. The result register lets the
// next word in while a result waits.
// Reset (async, active low) empties the set; stored entries are not cleared.
module sorted_set_insert_lookup_unit
  import ssil_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  fsm_e             state_q, state_d;
  in_word_t         req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  logic             present;
  logic             out_free;
  logic             ins_ok;
  logic             req_neg;
  cell_ctl_t        ctl;
  logic             red_en;
  status_e          status;

  assign out_free = !out_valid_q || out_ready_i;
  assign req_neg  = req_q.value[31];

  // Result status for the word in flight
  always_comb begin
    ins_ok = 1'b0;
    if (req_q.req_type) begin
      status = (!req_neg && present) ? STAT_FOUND : STAT_NOT_FOUND;
    end else if (req_neg) begin
      status = STAT_NEGATIVE;
    end else if (present) begin
      status = STAT_DUPLICATE;
    end else if (count_q == CNT_W'(CAPACITY)) begin
      status = STAT_FULL;
    end else begin
      status = STAT_INSERTED;
      ins_ok = 1'b1;
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    red_en      = 1'b0;
    ctl.cmp_en  = 1'b0;
    ctl.ins_en  = 1'b0;
    ctl.value   = req_q.value[VAL_W-1:0];
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = FSM_CMP;
        end
      end
      FSM_CMP: begin
        ctl.cmp_en = 1'b1;
        state_d    = FSM_RED;
      end
      FSM_RED: begin
        red_en  = 1'b1;
        state_d = FSM_DEC;
      end
      FSM_DEC: begin
        if (out_free) begin
          ctl.ins_en = ins_ok;
          if (ins_ok) begin
            count_d = count_q + CNT_W'(1);
          end
          out_valid_d             = 1'b1;
          out_d.status            = status;
          out_d.element_count     = 7'(count_d);
          state_d                 = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_word_i;
    end
    out_q <= out_d;
  end

  ssil_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .red_en_i  (red_en),
    .count_i   (count_q),
    .present_o (present)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Count never passes capacity
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // Count grows only along with a fresh inserted result
  a_count_ins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1)) && out_valid_o &&
      (out_word_o.status == STAT_INSERTED))
    else $error("count changed without an insert");

  // A pending result is never overwritten before it is taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_word_o))
    else $error("pending result lost");

  // Cells shift only in the decide step
  a_ins_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins_en |-> (state_q == FSM_DEC) && out_free && !req_q.req_type)
    else $error("shift outside decide step");

endmodule
